// ===== rtl/tvr_pkg.sv =====
package tvr_pkg;

    localparam int AXES   = 3;
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [1:0] LAST_AXIS = 2'd2;

    // register indexes on the config port
    localparam logic [2:0] CFG_ACCEL_X     = 3'd0;
    localparam logic [2:0] CFG_ACCEL_Y     = 3'd1;
    localparam logic [2:0] CFG_ACCEL_Z     = 3'd2;
    localparam logic [2:0] CFG_MAX_SPEED_X = 3'd3;
    localparam logic [2:0] CFG_MAX_SPEED_Y = 3'd4;
    localparam logic [2:0] CFG_MAX_SPEED_Z = 3'd5;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic        [15:0] elapsed;
    } t_in;

    typedef struct packed {
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
        logic signed [31:0] disp_z;
        logic               moved;
        logic signed [31:0] speed_x;
        logic signed [31:0] speed_y;
        logic signed [31:0] speed_z;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DTSQ,
        ST_LIN,
        ST_QUAD,
        ST_ADT,
        ST_DIRDT,
        ST_RAMP,
        ST_UPD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        A_DT,
        A_VEL,
        A_ACC,
        A_DIR
    } t_asel;

    typedef enum logic [1:0] {
        B_DT,
        B_DTSQ,
        B_DIRDT
    } t_bsel;

    typedef struct packed {
        t_state     step;
        logic [1:0] axis;
        t_asel      a_sel;
        t_bsel      b_sel;
        logic       in_ready;
    } t_ctl;

endpackage

// ===== rtl/three_axis_velocity_ramp.sv =====
// Channel | Dir | Handshake                   | Word
// in      | in  | i_in_valid / o_in_ready     | i_in_data  (dirs x/y/z, elapsed)
// out     | out | o_out_valid / i_out_ready   | o_out_data (disp x/y/z, moved, speeds)
// cfg     | in  | i_cfg_we (no wait)          | i_cfg_idx, i_cfg_data
//
// One word runs from acceptance to o_out_valid as one dt*dt product, then per axis five
// products on the shared 33x33 multiplier and the velocity write, then the output load.
// The next word is taken in the idle step after that, so a new word is not taken before
// the last one is through. All products go through that one multiplier.
// Reset (i_rst_n low, synchronous) clears velocities, config registers and o_out_valid.
// A result left waiting in the output register does not stop the next word being taken;
// the sequencer only holds in its output step if a newer result would overwrite it.
module three_axis_velocity_ramp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tvr_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tvr_pkg::t_out o_out_data,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [30:0]   i_cfg_data
);
    import tvr_pkg::*;

    t_ctl w_ctl;
    logic w_out_busy;
    logic w_in_acc;

    // latched word and per-item state
    t_in                r_in;
    logic               r_moving;
    logic signed [31:0] r_vel   [AXES];
    logic        [30:0] r_accel [AXES];
    logic        [30:0] r_max   [AXES];

    // intermediate products, shared by all axes, and the per-axis displacements
    logic        [31:0] r_dtsq;
    logic signed [47:0] r_lin;
    logic        [46:0] r_adt;
    logic signed [31:0] r_disp [AXES];

    t_out r_out;
    logic r_out_valid;

    assign w_out_busy = r_out_valid && !i_out_ready;
    assign w_in_acc   = i_in_valid && w_ctl.in_ready;

    tvr_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_out_busy (w_out_busy),
        .o_ctl      (w_ctl)
    );

    // --- current axis operands ---
    logic signed [31:0] w_vel;
    logic        [30:0] w_acc;
    logic        [30:0] w_max;
    logic signed [15:0] w_dir;

    assign w_vel = r_vel[w_ctl.axis];
    assign w_acc = r_accel[w_ctl.axis];
    assign w_max = r_max[w_ctl.axis];

    always_comb begin
        case (w_ctl.axis)
            2'd0:    w_dir = r_in.dir_x;
            2'd1:    w_dir = r_in.dir_y;
            default: w_dir = r_in.dir_z;
        endcase
    end

    // --- shared multiplier operand select ---
    logic signed [MUL_W-1:0] w_mul_a, w_mul_b;
    logic signed [PROD_W-1:0] w_prod;

    always_comb begin
        case (w_ctl.a_sel)
            A_VEL:   w_mul_a = {w_vel[31], w_vel};
            A_ACC:   w_mul_a = {2'b00, w_acc};
            A_DIR:   w_mul_a = {{17{w_dir[15]}}, w_dir};
            default: w_mul_a = {17'd0, r_in.elapsed};
        endcase
        case (w_ctl.b_sel)
            B_DTSQ:  w_mul_b = {1'b0, r_dtsq};
            // dir*dt straight from the multiplier output, registered in the previous step
            B_DIRDT: w_mul_b = {w_prod[31], w_prod[31:0]};
            default: w_mul_b = {17'd0, r_in.elapsed};
        endcase
    end

    tvr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // --- displacement: product holds a*dt*dt here ---
    // v*dt and a*dt*dt/2 both in Q.32, rounded to Q16.16, saturated.
    logic        [45:0] w_quad_sh;
    logic signed [48:0] w_sum;
    logic signed [48:0] w_sum_r;
    logic signed [32:0] w_q;
    logic signed [31:0] w_sat;
    logic signed [31:0] w_disp;

    always_comb begin
        w_quad_sh = w_prod[62:17];
        w_sum     = {r_lin[47], r_lin} + {3'b000, w_quad_sh};
        w_sum_r   = w_sum + 49'sd32768;
        w_q       = w_sum_r[48:16];
        if (w_q[32] != w_q[31]) begin
            w_sat = w_q[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_sat = w_q[31:0];
        end
        // no motion: zero; idle axis with no drive: zero
        if (r_moving && !(w_dir == 16'sd0 && w_vel == 32'sd0)) begin
            w_disp = w_sat;
        end else begin
            w_disp = 32'sd0;
        end
    end

    // --- velocity update: product holds dir*dt*a (Q.46) here ---
    logic signed [63:0] w_ramp;
    logic signed [63:0] w_ramp_r;
    logic signed [33:0] w_rnd;
    logic signed [34:0] w_vsum;
    logic signed [34:0] w_lim;
    logic        [47:0] w_step_r;
    logic        [31:0] w_step;
    logic signed [32:0] w_dec;
    logic signed [31:0] w_vel_new;

    always_comb begin
        w_ramp   = w_prod[63:0];
        w_ramp_r = w_ramp + 64'sd536870912;
        w_rnd    = w_ramp_r[63:30];
        w_vsum   = {{3{w_vel[31]}}, w_vel} + {w_rnd[33], w_rnd};
        w_lim    = {4'b0000, w_max};
        w_step_r = {1'b0, r_adt} + 48'd32768;
        w_step   = w_step_r[47:16];
        w_dec    = 33'sd0;
        if (w_dir != 16'sd0) begin
            if (w_vsum > w_lim) begin
                w_vel_new = w_lim[31:0];
            end else if (w_vsum < -w_lim) begin
                w_vel_new = 32'(-w_lim);
            end else begin
                w_vel_new = w_vsum[31:0];
            end
        end else begin
            // decay toward zero, never crossing it
            if (w_vel > 32'sd0) begin
                w_dec = {w_vel[31], w_vel} - {1'b0, w_step};
                w_vel_new = (w_dec < 33'sd0) ? 32'sd0 : w_dec[31:0];
            end else begin
                w_dec = {w_vel[31], w_vel} + {1'b0, w_step};
                w_vel_new = (w_dec > 33'sd0) ? 32'sd0 : w_dec[31:0];
            end
        end
    end

    // --- control state and config ---
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moving    <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < AXES; i++) begin
                r_vel[i]   <= 32'sd0;
                r_accel[i] <= 31'd0;
                r_max[i]   <= 31'd0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACCEL_X:     r_accel[0] <= i_cfg_data;
                    CFG_ACCEL_Y:     r_accel[1] <= i_cfg_data;
                    CFG_ACCEL_Z:     r_accel[2] <= i_cfg_data;
                    CFG_MAX_SPEED_X: r_max[0]   <= i_cfg_data;
                    CFG_MAX_SPEED_Y: r_max[1]   <= i_cfg_data;
                    CFG_MAX_SPEED_Z: r_max[2]   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_moving <= (r_vel[0] != 32'sd0) || (r_vel[1] != 32'sd0)
                         || (r_vel[2] != 32'sd0);
            end
            if (w_ctl.step == ST_UPD) begin
                r_vel[w_ctl.axis] <= w_vel_new;
            end
            if (w_ctl.step == ST_OUT && !w_out_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // --- payload registers ---
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        case (w_ctl.step)
            ST_LIN: begin
                if (w_ctl.axis == 2'd0) begin
                    r_dtsq <= w_prod[31:0];
                end
            end
            ST_QUAD:  r_lin   <= w_prod[47:0];
            ST_ADT:   r_disp[w_ctl.axis] <= w_disp;
            ST_DIRDT: r_adt   <= w_prod[46:0];
            ST_OUT: begin
                if (!w_out_busy) begin
                    r_out.disp_x  <= r_disp[0];
                    r_out.disp_y  <= r_disp[1];
                    r_out.disp_z  <= r_disp[2];
                    r_out.moved   <= r_moving;
                    r_out.speed_x <= r_vel[0];
                    r_out.speed_y <= r_vel[1];
                    r_out.speed_z <= r_vel[2];
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = w_ctl.in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/tvr_mul.sv =====
module tvr_mul (
    input  logic                            i_clk,
    input  logic signed [tvr_pkg::MUL_W-1:0]  i_a,
    input  logic signed [tvr_pkg::MUL_W-1:0]  i_b,
    output logic signed [tvr_pkg::PROD_W-1:0] o_prod
);
    import tvr_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/tvr_seq.sv =====
module tvr_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_out_busy,
    output tvr_pkg::t_ctl o_ctl
);
    import tvr_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_axis         = r_axis;
        o_ctl.step     = r_state;
        o_ctl.axis     = r_axis;
        o_ctl.a_sel    = A_DT;
        o_ctl.b_sel    = B_DT;
        o_ctl.in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ctl.in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_DTSQ;
                    n_axis  = 2'd0;
                end
            end
            ST_DTSQ: begin
                n_state = ST_LIN;
            end
            ST_LIN: begin
                o_ctl.a_sel = A_VEL;
                n_state     = ST_QUAD;
            end
            ST_QUAD: begin
                o_ctl.a_sel = A_ACC;
                o_ctl.b_sel = B_DTSQ;
                n_state     = ST_ADT;
            end
            ST_ADT: begin
                o_ctl.a_sel = A_ACC;
                n_state     = ST_DIRDT;
            end
            ST_DIRDT: begin
                o_ctl.a_sel = A_DIR;
                n_state     = ST_RAMP;
            end
            ST_RAMP: begin
                o_ctl.a_sel = A_ACC;
                o_ctl.b_sel = B_DIRDT;
                n_state     = ST_UPD;
            end
            ST_UPD: begin
                if (r_axis == LAST_AXIS) begin
                    n_state = ST_OUT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = ST_LIN;
                end
            end
            ST_OUT: begin
                if (!i_out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/tvr_chk.sv =====
module tvr_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input tvr_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input tvr_pkg::t_out o_out_data,
    input logic          i_cfg_we,
    input logic [2:0]    i_cfg_idx,
    input logic [30:0]   i_cfg_data
);
    import tvr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output word changed while stalled");

    a_rst_clr: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // no motion means zero displacement on every axis
    a_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.moved |->
            o_out_data.disp_x == 32'sd0 && o_out_data.disp_y == 32'sd0
            && o_out_data.disp_z == 32'sd0)
        else $error("displacement without motion");

    // one word at a time through the shared unit
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("word taken while busy");

    // idle sequencer has no newer result to load behind a taken one
    a_one_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_in_ready |=> !o_out_valid)
        else $error("result repeated");

endmodule

bind three_axis_velocity_ramp tvr_chk u_tvr_chk (.*);

// ===== verif/three_axis_velocity_ramp_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for three_axis_velocity_ramp.
// A directed table runs first, then random words under randomly chosen
// register settings. Every word taken by the block is fed through a local
// motion predictor, and each word it returns is checked field by field
// against the oldest outstanding prediction.
module three_axis_velocity_ramp_tb;
    import tvr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no word moving on either side
    localparam int DRAIN_CYCLES    = 40;    // comfortably over the time from acceptance to result
    localparam int SETTLE_CYCLES   = 4;
    localparam int RANDOM_PHASES   = 6;
    localparam int WORDS_PER_PHASE = 215;
    localparam int N_ROWS          = 22;
    localparam int MAX_REPORTS     = 10;

    localparam logic [30:0] REG_MAX  = 31'h7FFF_FFFF;
    localparam longint      DISP_MAX = 64'sd2147483647;
    localparam longint      DISP_MIN = -64'sd2147483648;

    // Register sets for the directed part
    localparam logic [1:0] SET_RESET    = 2'd0;  // left as after reset, never written
    localparam logic [1:0] SET_MODERATE = 2'd1;
    localparam logic [1:0] SET_EXTREME  = 2'd2;
    localparam logic [1:0] SET_NO_LIMIT = 2'd3;  // zero speed limit on x

    typedef struct packed {
        logic [1:0] cfg_set;
        logic       at_rest;  // expected word is all zero, typed in rather than predicted
        t_in        word;
    } t_row;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in         in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_idx   = CFG_ACCEL_X;
    logic [30:0] cfg_data  = '0;

    // Predictor state: velocities and a shadow of the registers
    logic signed [31:0] vel_q   [AXES];
    logic        [30:0] accel_q [AXES];
    logic        [30:0] vmax_q  [AXES];

    t_out due_motion [$];   // predicted words, oldest first
    t_out want_motion;
    t_row steps_tbl [N_ROWS];
    logic [5:0][30:0] cfg_sets [4];
    logic [5:0][30:0] random_set;
    logic [1:0] cur_set;

    int mismatches     = 0;
    int idle_cycles    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    three_axis_velocity_ramp dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Round to nearest by adding half an LSB, then arithmetic shift (floor).
    function automatic longint round_shr(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    // One time step of the motion: displacement from the old velocities,
    // then ramp or decay of each velocity. Updates the predictor state.
    function automatic t_out motion_step(t_in w);
        longint dir [AXES];
        longint dt, v, a, lim, lin, quad, sum;
        logic signed [31:0] disp [AXES];
        logic moving;
        t_out r;

        dir[0] = $signed(w.dir_x);
        dir[1] = $signed(w.dir_y);
        dir[2] = $signed(w.dir_z);
        dt     = w.elapsed;
        moving = (vel_q[0] != 0) || (vel_q[1] != 0) || (vel_q[2] != 0);

        for (int i = 0; i < AXES; i++) begin
            disp[i] = '0;
            // axis idle when both its direction and velocity are zero
            if (moving && !(dir[i] == 0 && vel_q[i] == 0)) begin
                v    = vel_q[i];
                a    = accel_q[i];
                lin  = v * dt;                      // Q.32
                quad = a * dt * dt;                 // Q.48
                sum  = round_shr(lin + (quad >>> 17), 16);
                if (sum > DISP_MAX)
                    sum = DISP_MAX;
                else if (sum < DISP_MIN)
                    sum = DISP_MIN;
                disp[i] = sum[31:0];
            end
        end

        for (int i = 0; i < AXES; i++) begin
            v = vel_q[i];
            a = accel_q[i];
            if (dir[i] != 0) begin
                lim = vmax_q[i];
                v   = v + round_shr(dir[i] * a * dt, 30);
                if (v > lim)
                    v = lim;
                else if (v < -lim)
                    v = -lim;
            end else begin
                // decay towards zero, never through it
                lin = round_shr(a * dt, 16);
                if (v > 0) begin
                    v = v - lin;
                    if (v < 0)
                        v = 0;
                end else begin
                    v = v + lin;
                    if (v > 0)
                        v = 0;
                end
            end
            vel_q[i] = v[31:0];
        end

        r.disp_x  = disp[0];
        r.disp_y  = disp[1];
        r.disp_z  = disp[2];
        r.moved   = moving;
        r.speed_x = vel_q[0];
        r.speed_y = vel_q[1];
        r.speed_z = vel_q[2];
        return r;
    endfunction

    function automatic t_row mk_row(logic [1:0] set, logic rest, logic [15:0] dx,
                                    logic [15:0] dy, logic [15:0] dz, logic [15:0] el);
        t_row r;
        r.cfg_set      = set;
        r.at_rest      = rest;
        r.word.dir_x   = dx;
        r.word.dir_y   = dy;
        r.word.dir_z   = dz;
        r.word.elapsed = el;
        return r;
    endfunction

    // Register values biased to the extremes and to sizes where ramps take
    // several steps before hitting the limit.
    function automatic logic [30:0] pick_reg();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return REG_MAX;
            2, 3:    return 31'($urandom_range(1, 1 << 20));
            4:       return 31'($urandom_range(1 << 20, 1 << 26));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_dir();
        case ($urandom_range(0, 7))
            0, 1:    return 16'h0000;
            2:       return 16'h4000;           // +1.0
            3:       return 16'hC000;           // -1.0
            4:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in pick_word();
        t_in w;
        // a fair share of all-zero directions so the axes come to rest
        if ($urandom_range(0, 4) == 0) begin
            w.dir_x = '0;
            w.dir_y = '0;
            w.dir_z = '0;
        end else begin
            w.dir_x = pick_dir();
            w.dir_y = pick_dir();
            w.dir_z = pick_dir();
        end
        case ($urandom_range(0, 7))
            0:       w.elapsed = '0;
            1:       w.elapsed = 16'hFFFF;
            2, 3, 4: w.elapsed = 16'($urandom_range(0, 4095));
            default: w.elapsed = 16'($urandom);
        endcase
        return w;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Offer one word and wait for it to be taken. Valid is left high on
    // return; the next call either keeps it high or drops it for a gap.
    // Ready is looked at mid-cycle, where it is settled for the coming edge.
    task automatic send_word(t_in w, logic rest);
        t_out pred;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
        pred = motion_step(w);
        due_motion.push_back(rest ? t_out'('0) : pred);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [30:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_ACCEL_X:     accel_q[0] = val;
            CFG_ACCEL_Y:     accel_q[1] = val;
            CFG_ACCEL_Z:     accel_q[2] = val;
            CFG_MAX_SPEED_X: vmax_q[0]  = val;
            CFG_MAX_SPEED_Y: vmax_q[1]  = val;
            CFG_MAX_SPEED_Z: vmax_q[2]  = val;
            default: ;
        endcase
    endtask

    // Order in the packed set: accel x/y/z, then speed limit x/y/z
    task automatic load_regs(logic [5:0][30:0] vals);
        write_reg(CFG_ACCEL_X,     vals[0]);
        write_reg(CFG_ACCEL_Y,     vals[1]);
        write_reg(CFG_ACCEL_Z,     vals[2]);
        write_reg(CFG_MAX_SPEED_X, vals[3]);
        write_reg(CFG_MAX_SPEED_Y, vals[4]);
        write_reg(CFG_MAX_SPEED_Z, vals[5]);
        cfg_we <= 1'b0;
    endtask

    // Stop offering words and let every outstanding result come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (due_motion.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: check mid-cycle against predictions for the word taken
    // at the coming edge
    always @(negedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (due_motion.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word with nothing outstanding: %h", out_data);
            end else begin
                want_motion = due_motion.pop_front();
                check_field("disp_x",  want_motion.disp_x,  out_data.disp_x);
                check_field("disp_y",  want_motion.disp_y,  out_data.disp_y);
                check_field("disp_z",  want_motion.disp_z,  out_data.disp_z);
                check_field("moved",   {31'd0, want_motion.moved}, {31'd0, out_data.moved});
                check_field("speed_x", want_motion.speed_x, out_data.speed_x);
                check_field("speed_y", want_motion.speed_y, out_data.speed_y);
                check_field("speed_z", want_motion.speed_z, out_data.speed_z);
            end
        end
    end

    // Random back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: a long run with no word moving either way means a hang
    always @(negedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("three_axis_velocity_ramp_tb failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < AXES; i++) begin
            vel_q[i]   = '0;
            accel_q[i] = '0;
            vmax_q[i]  = '0;
        end

        // listed high index first: vmax z, vmax y, vmax x, accel z, accel y, accel x
        cfg_sets[SET_RESET]    = '0;
        cfg_sets[SET_MODERATE] = {31'h0000_4000, 31'h0003_0000, 31'h0001_0000,
                                  31'h000A_0000, 31'h0000_8000, 31'h0002_0000};
        cfg_sets[SET_EXTREME]  = {REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX, REG_MAX};
        cfg_sets[SET_NO_LIMIT] = {REG_MAX, 31'h0001_0000, 31'h0000_0000,
                                  31'h0000_0001, REG_MAX, 31'h0004_0000};

        steps_tbl = '{
            // after reset: no acceleration, no limit, so nothing ever moves
            mk_row(SET_RESET,    1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
            mk_row(SET_RESET,    1'b1, 16'h4000, 16'hC000, 16'h7FFF, 16'hFFFF),
            mk_row(SET_RESET,    1'b1, 16'h8000, 16'h7FFF, 16'h0001, 16'h0001),
            // moderate set: at rest with no direction, then ramp, hold, decay, and a ramp on x alone
            mk_row(SET_MODERATE, 1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h8000),
            mk_row(SET_MODERATE, 1'b0, 16'h4000, 16'hC000, 16'h2000, 16'h4000),
            mk_row(SET_MODERATE, 1'b0, 16'h4000, 16'hC000, 16'h2000, 16'h4000),
            mk_row(SET_MODERATE, 1'b0, 16'h4000, 16'hC000, 16'h2000, 16'h0000),
            mk_row(SET_MODERATE, 1'b0, 16'h7FFF, 16'h8000, 16'h4000, 16'hFFFF),
            mk_row(SET_MODERATE, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h1000),
            mk_row(SET_MODERATE, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF),
            mk_row(SET_MODERATE, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF),
            mk_row(SET_MODERATE, 1'b0, 16'h4000, 16'h0000, 16'h0000, 16'h0800),
            mk_row(SET_MODERATE, 1'b0, 16'h4000, 16'h0000, 16'h0000, 16'h0800),
            // everything at full scale: displacement saturation
            mk_row(SET_EXTREME,  1'b0, 16'h4000, 16'h4000, 16'hC000, 16'hFFFF),
            mk_row(SET_EXTREME,  1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF),
            mk_row(SET_EXTREME,  1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF),
            mk_row(SET_EXTREME,  1'b0, 16'h8000, 16'h8000, 16'h7FFF, 16'hFFFF),
            mk_row(SET_EXTREME,  1'b0, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF),
            // zero speed limit on x: x held at zero while steering
            mk_row(SET_NO_LIMIT, 1'b0, 16'h4000, 16'h4000, 16'h4000, 16'h4000),
            mk_row(SET_NO_LIMIT, 1'b0, 16'hC000, 16'h8000, 16'h7FFF, 16'hFFFF),
            mk_row(SET_NO_LIMIT, 1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0001),
            mk_row(SET_NO_LIMIT, 1'b0, 16'h0001, 16'hFFFF, 16'h0000, 16'h0001)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, with the sender and receiver idling as in the first phase
        send_idle_pct  = 21;
        recv_stall_pct = 86;
        cur_set = SET_RESET;
        for (int r = 0; r < N_ROWS; r++) begin
            if (steps_tbl[r].cfg_set != cur_set) begin
                settle();
                cur_set = steps_tbl[r].cfg_set;
                load_regs(cfg_sets[cur_set]);
            end
            send_word(steps_tbl[r].word, steps_tbl[r].at_rest);
        end

        // random part: new registers each phase, idling pattern swapped from the third phase,
        // last two phases at full rate on both sides
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            for (int k = 0; k < 6; k++)
                random_set[k] = pick_reg();
            load_regs(random_set);
            if (p < 2) begin
                send_idle_pct  = 21;
                recv_stall_pct = 86;
            end else if (p < 4) begin
                send_idle_pct  = 86;
                recv_stall_pct = 21;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                send_word(pick_word(), 1'b0);
        end

        in_valid <= 1'b0;
        while (due_motion.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && due_motion.size() == 0)
            $display("three_axis_velocity_ramp_tb passed");
        else
            $display("three_axis_velocity_ramp_tb failed");
        $finish;
    end

endmodule
